### src/u8dc_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder and classifier package
// Types, lead byte tags and character class tables shared by the channel
// interfaces and the decoder.
// ----------------------------------------------------------------------------
package u8dc_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned LEFT_W  = 2;
  localparam int unsigned CONT_W  = 6;

  localparam logic [0:0] LEAD1_TAG = 1'b0;
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

  localparam logic [COUNT_W-1:0] LEN_NONE = 3'd0;
  localparam logic [COUNT_W-1:0] LEN_1    = 3'd1;
  localparam logic [COUNT_W-1:0] LEN_2    = 3'd2;
  localparam logic [COUNT_W-1:0] LEN_3    = 3'd3;
  localparam logic [COUNT_W-1:0] LEN_4    = 3'd4;

  localparam int unsigned SPACE_N = 26;
  localparam int unsigned DIGIT_N = 22;

  localparam logic [CP_W-1:0] SPACE_TAB [SPACE_N] = '{
    21'h0008, 21'h0009, 21'h000A, 21'h000B, 21'h000C, 21'h000D, 21'h0020, 21'h00A0,
    21'h2002, 21'h2003, 21'h2004, 21'h2005, 21'h2006, 21'h2007, 21'h2008, 21'h2009,
    21'h200A, 21'h200B, 21'h2028, 21'h2029, 21'h202D, 21'h202E, 21'h202F, 21'h205F,
    21'h3000, 21'hFEFF
  };

  // First digit of each script; every run holds ten digits except Ethiopic.
  localparam logic [CP_W-1:0] DIGIT_BASE [DIGIT_N] = '{
    21'h0030, 21'h0660, 21'h06F0, 21'h07C0, 21'h0966, 21'h09E6, 21'h0A66, 21'h0AE6,
    21'h0B66, 21'h0BE6, 21'h0C66, 21'h0CE6, 21'h0D66, 21'h0DE6, 21'h0E50, 21'h0ED0,
    21'h0F20, 21'h1040, 21'h1090, 21'h1369, 21'h17E0, 21'h1810
  };
  localparam logic [CP_W-1:0] ETHIOPIC_BASE = 21'h1369;
  localparam logic [CP_W-1:0] CTRL_HIGH     = 21'h0007;
  localparam logic [CP_W-1:0] CTRL_DEL      = 21'h007F;

  typedef struct packed {
    logic [CP_W-1:0]    code_point;
    logic [COUNT_W-1:0] byte_count;
    logic               invalid_lead;
    logic               is_space;
    logic               is_control;
    logic               is_digit;
    logic               is_alpha;
  } u8dc_res_t;

  function automatic logic space_match(input logic [CP_W-1:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < SPACE_N; i++) begin
      hit = hit | (cp == SPACE_TAB[i]);
    end
    return hit;
  endfunction

  function automatic logic digit_match(input logic [CP_W-1:0] cp);
    logic            hit;
    logic [CP_W-1:0] top;
    hit = 1'b0;
    for (int i = 0; i < DIGIT_N; i++) begin
      top = (DIGIT_BASE[i] == ETHIOPIC_BASE) ? DIGIT_BASE[i] + 21'd9 : DIGIT_BASE[i] + 21'd10;
      hit = hit | ((cp >= DIGIT_BASE[i]) && (cp < top));
    end
    return hit;
  endfunction

  function automatic logic alpha_match(input logic [BYTE_W-1:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

endpackage

### src/u8dc_if.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder channel interfaces
// Valid/ready channels for the byte stream and for decoded characters.
// ----------------------------------------------------------------------------
interface u8dc_byte_if
  import u8dc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface u8dc_char_if
  import u8dc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CP_W-1:0]    code_point;
  logic [COUNT_W-1:0] byte_count;
  logic               invalid_lead;
  logic               is_space;
  logic               is_control;
  logic               is_digit;
  logic               is_alpha;

  modport source (output valid, output code_point, output byte_count, output invalid_lead,
                  output is_space, output is_control, output is_digit, output is_alpha,
                  input ready);
  modport sink   (input valid, input code_point, input byte_count, input invalid_lead,
                  input is_space, input is_control, input is_digit, input is_alpha,
                  output ready);
endinterface

### src/utf8_decode_classify_top.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder and classifier
// Merges a UTF-8 byte stream into code points and flags each character.
// ----------------------------------------------------------------------------
// The byte stream enters on in_ch, one byte per item. Lead bytes open a
// sequence of one to four bytes and continuation bytes are merged six bits
// at a time. When a sequence completes, one item leaves on out_ch with the
// code point, byte count and the space, control, digit and alpha flags.
// A malformed lead byte gives an item at once with invalid_lead set.
// Bytes that only extend a sequence give no output item.
// An accepted byte is held in the input register; the decode and
// table compares run between it and the result register, which holds
// the result that out_ch shows.
// Throughput is one byte per cycle, set by the single decode stage, while out_ch takes each result.
// When out_ch stalls, the result register holds, the input register holds a
// byte that would produce a result, and in_ch drops ready only then.
// Reset clears the open sequence and both valid flags.
module utf8_decode_classify_top
  import u8dc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  u8dc_byte_if.sink   in_ch,
  u8dc_char_if.source out_ch
);

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic [LEFT_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [CP_W-1:0]   partial_r, partial_nxt;
  logic [COUNT_W-1:0] seq_len_r, seq_len_nxt;
  logic              out_valid_r;
  u8dc_res_t         res_r;
  u8dc_res_t         res_nxt;
  logic              emit;
  logic              out_free;
  logic              s1_adv;
  logic [CP_W-1:0]   cp_sel;

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    partial_nxt    = partial_r;
    seq_len_nxt    = seq_len_r;
    emit           = 1'b0;
    cp_sel         = '0;
    res_nxt        = '0;
    priority if (bytes_left_r != '0) begin
      partial_nxt    = {partial_r[CP_W-CONT_W-1:0], s1_byte_r[CONT_W-1:0]};
      bytes_left_nxt = bytes_left_r - 2'd1;
      emit           = (bytes_left_r == 2'd1);
      cp_sel         = partial_nxt;
      res_nxt.byte_count = seq_len_r;
    end else if (s1_byte_r[7] == LEAD1_TAG) begin
      partial_nxt = {13'd0, s1_byte_r};
      seq_len_nxt = LEN_1;
      emit        = 1'b1;
      cp_sel      = partial_nxt;
      res_nxt.byte_count = LEN_1;
      res_nxt.is_alpha   = alpha_match(s1_byte_r);
    end else if (s1_byte_r[7:5] == LEAD2_TAG) begin
      partial_nxt    = {16'd0, s1_byte_r[4:0]};
      seq_len_nxt    = LEN_2;
      bytes_left_nxt = 2'd1;
    end else if (s1_byte_r[7:4] == LEAD3_TAG) begin
      partial_nxt    = {17'd0, s1_byte_r[3:0]};
      seq_len_nxt    = LEN_3;
      bytes_left_nxt = 2'd2;
    end else if (s1_byte_r[7:3] == LEAD4_TAG) begin
      partial_nxt    = {18'd0, s1_byte_r[2:0]};
      seq_len_nxt    = LEN_4;
      bytes_left_nxt = 2'd3;
    end else begin
      emit                 = 1'b1;
      res_nxt.byte_count   = LEN_NONE;
      res_nxt.invalid_lead = 1'b1;
    end
    res_nxt.code_point = cp_sel;
    res_nxt.is_space   = space_match(cp_sel);
    res_nxt.is_control = (cp_sel <= CTRL_HIGH) || (cp_sel == CTRL_DEL);
    res_nxt.is_digit   = digit_match(cp_sel);
  end

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && (!emit || out_free);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      bytes_left_r <= '0;
      partial_r    <= '0;
      seq_len_r    <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s1_adv) begin
        bytes_left_r <= bytes_left_nxt;
        partial_r    <= partial_nxt;
        seq_len_r    <= seq_len_nxt;
      end
      if (out_free) begin
        out_valid_r <= s1_adv && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.byte_in;
    end
    if (out_free && s1_adv && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.code_point   = res_r.code_point;
  assign out_ch.byte_count   = res_r.byte_count;
  assign out_ch.invalid_lead = res_r.invalid_lead;
  assign out_ch.is_space     = res_r.is_space;
  assign out_ch.is_control   = res_r.is_control;
  assign out_ch.is_digit     = res_r.is_digit;
  assign out_ch.is_alpha     = res_r.is_alpha;

`ifndef NO_ASSERTIONS
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.invalid_lead |->
      res_r.code_point == '0 && res_r.byte_count == LEN_NONE && res_r.is_control)
    else $error("invalid lead result is not the code point zero result");

  a_left_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_left_r != '0 |-> seq_len_r > {1'b0, bytes_left_r})
    else $error("more continuation bytes expected than the sequence holds");

  a_alpha_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.is_alpha |->
      res_r.byte_count == LEN_1 && res_r.code_point < 21'h80)
    else $error("alpha flag set on a multi-byte character");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !in_ch.ready |=> s1_valid_r && $stable(s1_byte_r))
    else $error("input register changed while the input was stalled");
`endif

endmodule
